FILE: rtl/core/gcb_pkg.sv
// Package for the grid cell bucket update block: sizes, codes and the
// structs passed between its modules. No dependencies.
package gcb_pkg;

   // Sizing of the grid store
   localparam int CELL_CAPACITY = 8;
   localparam int GRID_CELLS    = 4096;
   localparam int PARTICLE_BITS = 16;

   // Fixed field widths of the channels and registers
   localparam int CFG_W     = 13;
   localparam int ROWIDX_W  = 12;
   localparam int COLIDX_W  = 12;
   localparam int PID_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int CELLNUM_W = 12;
   localparam int OCC_W     = 4;
   localparam int CSR_IDX_W = 1;

   // Derived widths
   localparam int CELL_AW = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
   localparam int CNT_W   = $clog2(CELL_CAPACITY + 1);
   localparam int PROD_W  = ROWIDX_W + CFG_W;
   localparam int SUM_W   = PROD_W + 1;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd1;
   localparam logic [CFG_W-1:0]     GRID_COLS_RST = 13'd64;
   localparam logic [CFG_W-1:0]     GRID_ROWS_RST = 13'd64;

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE      = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_RANGE     = 2'd3
   } status_type;

   // One cell's list of particle indices, kept as one memory word
   typedef logic [CELL_CAPACITY-1:0][PARTICLE_BITS-1:0] row_type;

   // Cell address and range flag from the address unit
   typedef struct packed {
      logic               oor;
      logic [CELL_AW-1:0] cell_addr;
   } addr_type;

   // Access to the cell memories
   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [CELL_AW-1:0] addr;
      row_type            wr_row;
      logic [CNT_W-1:0]   wr_count;
   } mem_req_type;

   // Outcome of one insert or remove on a cell
   typedef struct packed {
      logic             wr_en;
      row_type          row;
      logic [CNT_W-1:0] count;
      status_type       status;
   } upd_type;

endpackage

FILE: rtl/core/gcb_if.sv
// Channel interfaces of the grid cell bucket update block: request and
// response, each with valid/ready. Depends on gcb_pkg.
interface gcb_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [gcb_pkg::PID_W-1:0]      particle_id;
   logic [gcb_pkg::ROWIDX_W-1:0]   row_index;
   logic [gcb_pkg::COLIDX_W-1:0]   col_index;

   modport source (output valid, func, particle_id, row_index, col_index, input ready);
   modport sink   (input valid, func, particle_id, row_index, col_index, output ready);
endinterface

interface gcb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gcb_pkg::STATUS_W-1:0]   status;
   logic [gcb_pkg::CELLNUM_W-1:0]  cell_number;
   logic [gcb_pkg::OCC_W-1:0]      occupancy;

   modport source (output valid, status, cell_number, occupancy, input ready);
   modport sink   (input valid, status, cell_number, occupancy, output ready);
endinterface

FILE: rtl/core/gcb_addr.sv
// Address unit: registers row times columns at accept, then adds the
// column and checks the range. Depends on gcb_pkg.
module gcb_addr (
   input  logic                          clock,
   input  logic                          load,
   input  logic [gcb_pkg::ROWIDX_W-1:0]  row_index,
   input  logic [gcb_pkg::COLIDX_W-1:0]  col_index,
   input  logic [gcb_pkg::CFG_W-1:0]     grid_cols,
   input  logic [gcb_pkg::CFG_W-1:0]     grid_rows,
   output gcb_pkg::addr_type             addr
);
   import gcb_pkg::*;

   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [COLIDX_W-1:0] col_ff, col_in;
   logic                bound_ff, bound_in;
   logic [SUM_W-1:0]    sum;

   // Multiply and bound checks on the incoming item
   always_comb begin
      prod_in  = prod_ff;
      col_in   = col_ff;
      bound_in = bound_ff;
      if (load) begin
         prod_in  = PROD_W'(row_index) * PROD_W'(grid_cols);
         col_in   = col_index;
         bound_in = (CFG_W'(row_index) >= grid_rows) || (CFG_W'(col_index) >= grid_cols);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      col_ff   <= col_in;
      bound_ff <= bound_in;
   end

   // Flat cell number and full range check
   always_comb begin
      sum            = SUM_W'(prod_ff) + SUM_W'(col_ff);
      addr.oor       = bound_ff || (sum >= SUM_W'(GRID_CELLS));
      addr.cell_addr = sum[CELL_AW-1:0];
   end

endmodule

FILE: rtl/core/gcb_cell_mem.sv
// Cell memories: one word of particle indices and one count per cell,
// registered reads, count clearing pass after reset. Depends on gcb_pkg.
module gcb_cell_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  gcb_pkg::mem_req_type          mreq,
   output gcb_pkg::row_type              rd_row,
   output logic [gcb_pkg::CNT_W-1:0]     rd_count,
   output logic                          busy
);
   import gcb_pkg::*;

   localparam logic [CELL_AW-1:0] CELL_LAST = CELL_AW'(GRID_CELLS - 1);

   row_type          entry_mem [GRID_CELLS];
   logic [CNT_W-1:0] count_mem [GRID_CELLS];

   logic               clr_ff, clr_in;
   logic [CELL_AW-1:0] clr_addr_ff, clr_addr_in;

   // Clearing pass over the counts
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         if (clr_addr_ff == CELL_LAST) begin
            clr_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign busy = clr_ff;

   // Entry word memory
   always_ff @(posedge clock) begin
      if (mreq.wr_en) begin
         entry_mem[mreq.addr] <= mreq.wr_row;
      end
      if (mreq.rd_en) begin
         rd_row <= entry_mem[mreq.addr];
      end
   end

   // Count memory, shared with the clearing pass
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         count_mem[clr_addr_ff] <= '0;
      end else if (mreq.wr_en) begin
         count_mem[mreq.addr] <= mreq.wr_count;
      end
      if (mreq.rd_en) begin
         rd_count <= count_mem[mreq.addr];
      end
   end

endmodule

FILE: rtl/core/gcb_update.sv
// Cell update logic: append on insert, first-match search and shift-down
// on remove, with full and not-found checks. Depends on gcb_pkg.
module gcb_update (
   input  gcb_pkg::func_type                  func,
   input  logic [gcb_pkg::PARTICLE_BITS-1:0]  pid,
   input  gcb_pkg::row_type                   row,
   input  logic [gcb_pkg::CNT_W-1:0]          count,
   output gcb_pkg::upd_type                   upd
);
   import gcb_pkg::*;

   localparam int IDX_W = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;

   row_type     shifted;
   logic        found;
   logic [IDX_W-1:0] hit_idx;

   always_comb begin
      shifted = row_type'(row >> PARTICLE_BITS);
      found   = 1'b0;
      hit_idx = '0;
      // Walk down so the lowest matching filled slot wins
      for (int i = CELL_CAPACITY - 1; i >= 0; i--) begin
         if ((CNT_W'(i) < count) && (row[i] == pid)) begin
            found   = 1'b1;
            hit_idx = IDX_W'(i);
         end
      end

      upd.row = row;
      unique case (func)
         FUNC_INSERT: begin
            if (count >= CNT_W'(CELL_CAPACITY)) begin
               upd.wr_en  = 1'b0;
               upd.count  = count;
               upd.status = STAT_FULL;
            end else begin
               for (int i = 0; i < CELL_CAPACITY; i++) begin
                  if (CNT_W'(i) == count) begin
                     upd.row[i] = pid;
                  end
               end
               upd.wr_en  = 1'b1;
               upd.count  = count + 1'b1;
               upd.status = STAT_DONE;
            end
         end
         FUNC_REMOVE: begin
            if (found) begin
               // Later entries move down one slot from the hit onward
               for (int i = 0; i < CELL_CAPACITY; i++) begin
                  if (IDX_W'(i) >= hit_idx) begin
                     upd.row[i] = shifted[i];
                  end
               end
               upd.wr_en  = 1'b1;
               upd.count  = count - 1'b1;
               upd.status = STAT_DONE;
            end else begin
               upd.wr_en  = 1'b0;
               upd.count  = count;
               upd.status = STAT_NOT_FOUND;
            end
         end
         default: begin
            upd.wr_en  = 1'b0;
            upd.count  = count;
            upd.status = STAT_NOT_FOUND;
         end
      endcase
   end

endmodule

FILE: rtl/core/grid_cell_bucket_update_top.sv
// Top level of the grid cell bucket update block: configuration registers,
// request sequencer and response register.
// Depends on gcb_pkg, gcb_if, gcb_addr, gcb_cell_mem and gcb_update.
//
// Usage:
//   req_ch carries one insert or remove item (func, particle_id, row_index,
//   col_index); rsp_ch returns one item per request (status, cell_number,
//   occupancy) in request order. csr_we/csr_index/csr_wdata write grid_cols
//   (index 0) and grid_rows (index 1); write them only while idle.
//   An item goes through accept with row times columns registered, a
//   lookup cycle that adds the column, checks range and reads the cell
//   word and count, and a modify cycle that writes the cell back and loads
//   the response register. The single-port read-modify-write of the cell
//   word sets this order; one item is in work at a time.
//   After reset the cell counts are cleared one cell per cycle, with
//   req_ch.ready low; csr writes are taken meanwhile.
//   If rsp_ch is stalled the finished item waits in the response register;
//   the next request is still accepted and looked up, and holds in the
//   modify cycle until the response register is free.
module grid_cell_bucket_update_top (
   input  logic                            clock,
   input  logic                            reset,
   gcb_req_if.sink                         req_ch,
   gcb_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [gcb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gcb_pkg::CFG_W-1:0]       csr_wdata
);
   import gcb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MOD
   } state_type;

   state_type              state_ff, state_in;
   logic [CFG_W-1:0]       cols_ff, cols_in;
   logic [CFG_W-1:0]       rows_ff, rows_in;
   func_type               func_ff, func_in;
   logic [PARTICLE_BITS-1:0] pid_ff, pid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [CELLNUM_W-1:0]   cellnum_ff, cellnum_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;

   addr_type               addr;
   mem_req_type            mreq;
   row_type                rd_row;
   logic [CNT_W-1:0]       rd_count;
   logic                   busy;
   upd_type                upd;
   logic                   req_fire;
   logic                   out_free;

   assign req_ch.ready = (state_ff == ST_IDLE) && !busy;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   gcb_addr u_addr (
      .clock     (clock),
      .load      (req_fire),
      .row_index (req_ch.row_index),
      .col_index (req_ch.col_index),
      .grid_cols (cols_ff),
      .grid_rows (rows_ff),
      .addr      (addr)
   );

   gcb_cell_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .mreq     (mreq),
      .rd_row   (rd_row),
      .rd_count (rd_count),
      .busy     (busy)
   );

   gcb_update u_upd (
      .func  (func_ff),
      .pid   (pid_ff),
      .row   (rd_row),
      .count (rd_count),
      .upd   (upd)
   );

   // Memory access: read in lookup, write back in modify
   always_comb begin
      mreq.rd_en    = (state_ff == ST_LOOK) && !addr.oor;
      mreq.wr_en    = (state_ff == ST_MOD) && out_free && !addr.oor && upd.wr_en;
      mreq.addr     = addr.cell_addr;
      mreq.wr_row   = upd.row;
      mreq.wr_count = upd.count;
   end

   // Configuration registers
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_COLS: cols_in = csr_wdata;
            CSR_GRID_ROWS: rows_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and response register
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      pid_in       = pid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      cellnum_in   = cellnum_ff;
      occ_in       = occ_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               func_in  = func_type'(req_ch.func);
               pid_in   = PARTICLE_BITS'(req_ch.particle_id);
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (addr.oor) begin
                  status_in  = STAT_RANGE;
                  cellnum_in = '0;
                  occ_in     = '0;
               end else begin
                  status_in  = upd.status;
                  cellnum_in = CELLNUM_W'(addr.cell_addr);
                  occ_in     = OCC_W'(upd.count);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cols_ff      <= GRID_COLS_RST;
         rows_ff      <= GRID_ROWS_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
      end
      func_ff    <= func_in;
      pid_ff     <= pid_in;
      status_ff  <= status_in;
      cellnum_ff <= cellnum_in;
      occ_ff     <= occ_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.cell_number = cellnum_ff;
   assign rsp_ch.occupancy   = occ_ff;

endmodule
